>>> rtl/msds_pkg.sv
// Shared types, constants and helpers for the motif site distance scanner.
package msds_pkg;

    localparam int MAX_MOTIF  = 8;
    localparam int CHAR_W     = 8;
    localparam int LEN_W      = 4;
    localparam int CELL_IDX_W = $clog2(MAX_MOTIF);
    localparam int MOTIF_W    = MAX_MOTIF * CHAR_W;
    localparam int CNT_W      = 32;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic [CNT_W-1:0] CNT_MAX   = '1;
    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(4);

    typedef enum logic [0:0] {
        REG_MOTIF_CHARS = 1'b0,
        REG_MOTIF_LEN   = 1'b1
    } cfg_reg_t;

    typedef enum logic [0:0] {
        KIND_DISTANCE = 1'b0,
        KIND_SUMMARY  = 1'b1
    } kind_t;

    // What the cell row hands to the site tracker for one item.
    typedef struct packed {
        logic             match;
        logic             eos;
        logic [CNT_W-1:0] start;
        logic [CNT_W-1:0] seq_len;
    } scan_t;

    typedef struct packed {
        kind_t            kind;
        logic [CNT_W-1:0] distance;
        logic [CNT_W-1:0] pre_dist;
        logic [CNT_W-1:0] post_dist;
        logic [CNT_W-1:0] site_count;
        logic             enough_sites;
        logic             last;
    } result_t;

    // Cell k holds the k-th newest character, which must equal motif byte len-1-k.
    function automatic logic [CHAR_W-1:0] expected_byte(
        input logic [MOTIF_W-1:0]    motif,
        input logic [LEN_W-1:0]      len_used,
        input logic [CELL_IDX_W-1:0] cell_idx
    );
        logic [CELL_IDX_W-1:0] sel;
        sel = CELL_IDX_W'(len_used - LEN_W'(1) - LEN_W'(cell_idx));
        return motif[sel*CHAR_W +: CHAR_W];
    endfunction

endpackage

>>> rtl/msds_cell.sv
// One window cell: holds a character, passes it on and compares the incoming one.
module msds_cell
    import msds_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              shift_en,
    input  logic [CHAR_W-1:0] d_in,
    input  logic [CHAR_W-1:0] exp_byte,
    input  logic              in_use,
    output logic [CHAR_W-1:0] q,
    output logic              hit
);

    logic [CHAR_W-1:0] char_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_reg <= '0;
        end
        else if (shift_en)
        begin
            char_reg <= d_in;
        end
    end

    // The compare looks at the character this cell takes on the current shift.
    assign hit = !in_use || (d_in == exp_byte);
    assign q   = char_reg;

endmodule

>>> rtl/msds_tracker.sv
// Site tracker: keeps per-sequence site state and forms up to two results per item.
module msds_tracker
    import msds_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    fire,
    input  scan_t   scan,
    output result_t res0,
    output logic    res0_valid,
    output result_t res1,
    output logic    res1_valid
);

    logic [CNT_W-1:0] last_site_reg, last_site_next;
    logic             have_site_reg, have_site_next;
    logic             first_seen_reg, first_seen_next;
    logic [CNT_W-1:0] prefix_reg, prefix_next;
    logic [CNT_W-1:0] count_reg, count_next;

    logic             emit_dist;
    logic [CNT_W-1:0] site_gap;
    logic [CNT_W-1:0] count_after;
    logic             first_after;
    logic [CNT_W-1:0] prefix_after;
    logic [CNT_W-1:0] last_after;
    logic [CNT_W-1:0] post_val;
    result_t          dist_res;
    result_t          sum_res;

    always_comb
    begin
        emit_dist    = scan.match && have_site_reg;
        site_gap     = scan.start - last_site_reg;
        count_after  = (emit_dist && (count_reg != CNT_MAX)) ? count_reg + CNT_W'(1) : count_reg;
        first_after  = first_seen_reg || emit_dist;
        prefix_after = (emit_dist && !first_seen_reg) ? last_site_reg : prefix_reg;
        last_after   = scan.match ? scan.start : last_site_reg;
        post_val     = (scan.seq_len > last_after) ? scan.seq_len - last_after - CNT_W'(1) : '0;

        dist_res              = '0;
        dist_res.kind         = KIND_DISTANCE;
        dist_res.distance     = site_gap;
        dist_res.last         = !scan.eos;

        sum_res               = '0;
        sum_res.kind          = KIND_SUMMARY;
        sum_res.pre_dist      = first_after ? prefix_after : '0;
        sum_res.post_dist     = first_after ? post_val : '0;
        sum_res.site_count    = count_after;
        sum_res.enough_sites  = first_after;
        sum_res.last          = 1'b1;
    end

    // The first slot carries the distance when there is one, else the summary.
    always_comb
    begin
        res0       = emit_dist ? dist_res : sum_res;
        res0_valid = emit_dist || scan.eos;
        res1       = sum_res;
        res1_valid = emit_dist && scan.eos;
    end

    always_comb
    begin
        last_site_next  = last_site_reg;
        have_site_next  = have_site_reg;
        first_seen_next = first_seen_reg;
        prefix_next     = prefix_reg;
        count_next      = count_reg;
        if (fire)
        begin
            if (scan.eos)
            begin
                last_site_next  = '0;
                have_site_next  = 1'b0;
                first_seen_next = 1'b0;
                prefix_next     = '0;
                count_next      = '0;
            end
            else
            begin
                last_site_next  = last_after;
                have_site_next  = have_site_reg || scan.match;
                first_seen_next = first_after;
                prefix_next     = prefix_after;
                count_next      = count_after;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_site_reg  <= '0;
            have_site_reg  <= 1'b0;
            first_seen_reg <= 1'b0;
            prefix_reg     <= '0;
            count_reg      <= '0;
        end
        else
        begin
            last_site_reg  <= last_site_next;
            have_site_reg  <= have_site_next;
            first_seen_reg <= first_seen_next;
            prefix_reg     <= prefix_next;
            count_reg      <= count_next;
        end
    end

endmodule

>>> rtl/msds_result_fifo.sv
// Small result queue that takes up to two items per cycle and gives one when the reader is ready.
module msds_result_fifo
    import msds_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    wr0,
    input  result_t d0,
    input  logic    wr1,
    input  result_t d1,
    output logic    space2,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    result_t               mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] head_reg, head_next;
    logic [FIFO_PTR_W-1:0] tail_reg, tail_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic                  pop;
    logic [FIFO_CNT_W-1:0] push_n;

    always_comb
    begin
        pop        = out_valid && out_ready;
        push_n     = FIFO_CNT_W'(wr0) + FIFO_CNT_W'(wr1);
        head_next  = head_reg + FIFO_PTR_W'(pop);
        tail_next  = tail_reg + FIFO_PTR_W'(push_n);
        count_next = count_reg + push_n - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr0)
        begin
            mem[tail_reg] <= d0;
        end
        if (wr1)
        begin
            mem[tail_reg + FIFO_PTR_W'(1)] <= d1;
        end
    end

    assign space2    = count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2);
    assign out_valid = count_reg != '0;
    assign out_data  = mem[head_reg];

endmodule

>>> rtl/motif_site_distance_scanner.sv
// Top level of the motif site distance scanner.
//
//  channel  direction  carries
//  s_*      in         tdata[7:0] = ch, tlast = end_of_seq
//  m_*      out        tdata = distance, pre_dist, post_dist, site_count, enough_sites;
//                      tuser = kind, tlast = last
//  cfg_*    in         cfg_index 0 = motif_chars, 1 = motif_len
//
// One character is accepted per cycle while s_tready is high; the match is registered
// after the cell row, and the results enter the output queue once it has room for two.
// The single output port sets the rate when an item causes two results.
// Reset clears the window, counters and queue; motif_len comes up as 4.
// A stalled output only holds the input once the four-entry queue cannot take two more.
module motif_site_distance_scanner
    import msds_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [CHAR_W-1:0]   s_tdata,   // [7:0] ch
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [135:0]        m_tdata,   // [31:0] distance, [63:32] pre_dist,
                                           // [95:64] post_dist, [127:96] site_count,
                                           // [128] enough_sites, rest zero
    output logic                m_tuser,   // [0] kind
    output logic                m_tlast,
    input  logic                cfg_we,
    input  cfg_reg_t            cfg_index,
    input  logic [MOTIF_W-1:0]  cfg_data
);

    logic [MOTIF_W-1:0] motif_chars_reg;
    logic [LEN_W-1:0]   motif_len_reg;
    logic [LEN_W-1:0]   len_used;
    logic [CNT_W-1:0]   pos_reg, pos_next;
    logic [CNT_W-1:0]   seq_len;
    logic               s1_valid_reg, s1_valid_next;
    scan_t              s1_reg, s1_next;
    logic               accept;
    logic               consume;
    logic               space2;
    logic [CHAR_W-1:0]  cell_q   [MAX_MOTIF];
    logic [MAX_MOTIF-1:0] hits;
    result_t            res0, res1, out_res;
    logic               res0_valid, res1_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motif_chars_reg <= '0;
            motif_len_reg   <= LEN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MOTIF_CHARS: motif_chars_reg <= cfg_data;
                REG_MOTIF_LEN:   motif_len_reg   <= cfg_data[LEN_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        if (motif_len_reg == '0)
        begin
            len_used = LEN_W'(1);
        end
        else if (motif_len_reg > LEN_W'(MAX_MOTIF))
        begin
            len_used = LEN_W'(MAX_MOTIF);
        end
        else
        begin
            len_used = motif_len_reg;
        end
    end

    assign accept  = s_tvalid && s_tready;
    assign consume = s1_valid_reg && space2;
    assign s_tready = !s1_valid_reg || space2;

    genvar k;
    generate
        for (k = 0; k < MAX_MOTIF; k++)
        begin : g_cell
            logic [CHAR_W-1:0] d_in;
            if (k == 0)
            begin : g_head
                assign d_in = s_tdata;
            end
            else
            begin : g_body
                assign d_in = cell_q[k-1];
            end
            msds_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .shift_en (accept),
                .d_in     (d_in),
                .exp_byte (expected_byte(motif_chars_reg, len_used, CELL_IDX_W'(k))),
                .in_use   (LEN_W'(k) < len_used),
                .q        (cell_q[k]),
                .hit      (hits[k])
            );
        end
    endgenerate

    always_comb
    begin
        seq_len        = (pos_reg == CNT_MAX) ? pos_reg : pos_reg + CNT_W'(1);
        pos_next       = pos_reg;
        s1_valid_next  = s1_valid_reg;
        s1_next        = s1_reg;
        if (consume)
        begin
            s1_valid_next = 1'b0;
        end
        if (accept)
        begin
            pos_next         = s_tlast ? '0 : seq_len;
            s1_valid_next    = 1'b1;
            // The window is full enough once position reaches motif length minus one.
            s1_next.match    = (&hits) && (pos_reg >= CNT_W'(len_used - LEN_W'(1)));
            s1_next.eos      = s_tlast;
            s1_next.start    = pos_reg - CNT_W'(len_used - LEN_W'(1));
            s1_next.seq_len  = seq_len;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg      <= pos_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_reg <= s1_next;
    end

    msds_tracker u_tracker (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (consume),
        .scan       (s1_reg),
        .res0       (res0),
        .res0_valid (res0_valid),
        .res1       (res1),
        .res1_valid (res1_valid)
    );

    msds_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr0       (consume && res0_valid),
        .d0        (res0),
        .wr1       (consume && res1_valid),
        .d1        (res1),
        .space2    (space2),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    assign m_tdata = {7'b0, out_res.enough_sites, out_res.site_count, out_res.post_dist,
                      out_res.pre_dist, out_res.distance};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last;

endmodule

>>> rtl/msds_checker.sv
// Port-level checks for the motif site distance scanner, bound to the top level.
module msds_checker
    import msds_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [135:0]       m_tdata,
    input logic               m_tuser,
    input logic               m_tlast
);

    // A result that waits keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

    // A summary always closes the results of its item.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_SUMMARY) |-> m_tlast)
        else $error("summary without last");

    // A distance item carries nothing but the distance.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_DISTANCE) |-> (m_tdata[135:32] == '0))
        else $error("distance item with summary fields set");

    // Without two sites the summary has no prefix, postfix or distances.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_SUMMARY) && !m_tdata[128] |-> (m_tdata[127:32] == '0))
        else $error("summary fields set with too few sites");

endmodule

bind motif_site_distance_scanner msds_checker u_msds_checker (.*);

>>> sim/tb_motif_site_distance_scanner.sv
// Self-checking testbench for the motif site distance scanner: directed and random sequences, checked results.
`timescale 1ns / 100ps

module tb_motif_site_distance_scanner;
    import msds_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASE_ITEMS   = 125;
    localparam int NUM_PHASES    = 10;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              eos;
    } char_item_t;

    logic                clk;
    logic                rst_n      = 1'b0;
    logic                s_tvalid   = 1'b0;
    logic                s_tready;
    logic [CHAR_W-1:0]   s_tdata    = '0;
    logic                s_tlast    = 1'b0;
    logic                m_tvalid;
    logic                m_tready   = 1'b0;
    logic [135:0]        m_tdata;
    logic                m_tuser;
    logic                m_tlast;
    logic                cfg_we     = 1'b0;
    cfg_reg_t            cfg_index  = REG_MOTIF_CHARS;
    logic [MOTIF_W-1:0]  cfg_data   = '0;

    // Characters waiting to be sent and results the scanner still owes.
    char_item_t  char_queue[$];
    result_t     due_results[$];

    // Shadow of the scanner's configuration and sequence state.
    logic [MOTIF_W-1:0]  motif_reg;
    logic [LEN_W-1:0]    mlen_reg;
    logic [CHAR_W-1:0]   window[MAX_MOTIF];
    logic [CNT_W-1:0]    seq_pos;
    logic [CNT_W-1:0]    last_site;
    logic                have_site;
    logic                dist_seen;
    logic [CNT_W-1:0]    prefix;
    logic [CNT_W-1:0]    dist_count;

    int          errors;
    int          src_gap;
    int          snk_gap;
    int          stall_cycles;
    bit          idle_on;
    char_item_t  next_item;
    result_t     want;

    motif_site_distance_scanner i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic int unsigned motif_span();
        if (mlen_reg == 0)
            return 1;
        if (mlen_reg > MAX_MOTIF)
            return MAX_MOTIF;
        return 32'(mlen_reg);
    endfunction

    task automatic clear_sequence();
        int i;
        for (i = 0; i < MAX_MOTIF; i++)
            window[i] = '0;
        seq_pos    = '0;
        last_site  = '0;
        have_site  = 1'b0;
        dist_seen  = 1'b0;
        prefix     = '0;
        dist_count = '0;
    endtask

    // Shifts one character into the window and queues the distance and summary it causes.
    task automatic predict_sites(input logic [CHAR_W-1:0] ch, input logic eos);
        int unsigned span;
        int          i;
        logic [CNT_W-1:0] p;
        logic [CNT_W-1:0] seq_len;
        logic [CNT_W-1:0] start;
        logic             hit;
        result_t          r;
        span    = motif_span();
        p       = seq_pos;
        seq_len = (p == CNT_MAX) ? p : p + 1;
        for (i = MAX_MOTIF - 1; i > 0; i--)
            window[i] = window[i-1];
        window[0] = ch;
        hit = ({1'b0, p} + 33'd1 >= 33'(span));
        for (i = 0; i < span; i++)
            if (window[span-1-i] != motif_reg[8*i +: 8])
                hit = 1'b0;
        if (hit)
        begin
            start = p - CNT_W'(span - 1);
            if (have_site)
            begin
                if (!dist_seen)
                begin
                    prefix    = last_site;
                    dist_seen = 1'b1;
                end
                r          = '0;
                r.kind     = KIND_DISTANCE;
                r.distance = start - last_site;
                r.last     = !eos;
                due_results = {due_results, r};
                if (dist_count != CNT_MAX)
                    dist_count++;
            end
            last_site = start;
            have_site = 1'b1;
        end
        seq_pos = seq_len;
        if (eos)
        begin
            r = '0;
            r.kind = KIND_SUMMARY;
            if (dist_seen)
            begin
                r.pre_dist  = prefix;
                r.post_dist = (seq_len > last_site) ? seq_len - last_site - 1 : '0;
            end
            r.site_count   = dist_count;
            r.enough_sites = dist_seen;
            r.last         = 1'b1;
            due_results = {due_results, r};
            clear_sequence();
        end
    endtask

    task automatic report_mismatch(input string what);
        errors++;
        if (errors < 100)
            $display("mismatch at %0t ns: %s", $time, what);
    endtask

    // Sender: one item per free slot, with random gaps while idling is on.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
            src_gap  = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_sites(s_tdata, s_tlast);
            if (!s_tvalid || s_tready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (char_queue.size() > 0)
                begin
                    next_item = char_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_item.ch;
                    s_tlast  <= next_item.eos;
                    if (idle_on && $urandom_range(0, 9) == 0)
                        src_gap = $urandom_range(1, 14);
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each result against the oldest one owed, stalls in bursts while idling is on.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            snk_gap  = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (due_results.size() == 0)
                begin
                    report_mismatch("result arrived with nothing expected");
                end
                else
                begin
                    want = due_results.pop_front();
                    if (m_tuser !== want.kind)
                        report_mismatch($sformatf("kind %0b, want %0b", m_tuser, want.kind));
                    if (m_tdata[31:0] !== want.distance)
                        report_mismatch($sformatf("distance %0d, want %0d",
                                                  m_tdata[31:0], want.distance));
                    if (m_tdata[63:32] !== want.pre_dist)
                        report_mismatch($sformatf("pre_dist %0d, want %0d",
                                                  m_tdata[63:32], want.pre_dist));
                    if (m_tdata[95:64] !== want.post_dist)
                        report_mismatch($sformatf("post_dist %0d, want %0d",
                                                  m_tdata[95:64], want.post_dist));
                    if (m_tdata[127:96] !== want.site_count)
                        report_mismatch($sformatf("site_count %0d, want %0d",
                                                  m_tdata[127:96], want.site_count));
                    if (m_tdata[128] !== want.enough_sites)
                        report_mismatch($sformatf("enough_sites %0b, want %0b",
                                                  m_tdata[128], want.enough_sites));
                    if (m_tlast !== want.last)
                        report_mismatch($sformatf("last %0b, want %0b", m_tlast, want.last));
                end
            end
            if (snk_gap > 0)
            begin
                snk_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (idle_on && $urandom_range(0, 7) == 0)
                    snk_gap = $urandom_range(1, 14);
            end
        end
    end

    // Ends the run if neither side moves an item for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Returns once every character is sent, every result is in and the pipeline is empty.
    task automatic wait_idle();
        while (char_queue.size() != 0 || s_tvalid || due_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_motif(input logic [MOTIF_W-1:0] chars, input logic [LEN_W-1:0] len);
        logic [MOTIF_W-1:0] len_word;
        wait_idle();
        len_word = {$urandom, $urandom};
        len_word[LEN_W-1:0] = len;
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_MOTIF_CHARS;
        cfg_data  <= chars;
        motif_reg = chars;
        @(posedge clk);
        cfg_index <= REG_MOTIF_LEN;
        cfg_data  <= len_word;
        mlen_reg = len;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic push_chars(input logic [CHAR_W-1:0] chars[$]);
        int i;
        char_item_t it;
        for (i = 0; i < chars.size(); i++)
        begin
            it.ch  = chars[i];
            it.eos = (i == chars.size() - 1);
            char_queue = {char_queue, it};
        end
    endtask

    // Builds n characters rich in motif copies; the last one ends the sequence if close is set.
    task automatic add_sequence(input int n, input bit close);
        int          count;
        int          j;
        int unsigned span;
        char_item_t  it;
        span  = motif_span();
        count = 0;
        while (count < n)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3:
                begin
                    for (j = 0; j < span && count < n; j++)
                    begin
                        it.ch = motif_reg[8*j +: 8];
                        it.eos = close && (count == n - 1);
                        char_queue = {char_queue, it};
                        count++;
                    end
                end
                4, 5, 6:
                begin
                    it.ch = motif_reg[8*$urandom_range(0, span - 1) +: 8];
                    it.eos = close && (count == n - 1);
                    char_queue = {char_queue, it};
                    count++;
                end
                default:
                begin
                    it.ch = CHAR_W'($urandom_range(0, 255));
                    it.eos = close && (count == n - 1);
                    char_queue = {char_queue, it};
                    count++;
                end
            endcase
        end
    endtask

    initial
    begin
        int                 ph;
        int                 added;
        int                 n;
        logic [CHAR_W-1:0]  b0;
        logic [CHAR_W-1:0]  b1;
        logic [MOTIF_W-1:0] chars;
        logic [LEN_W-1:0]   len;
        errors       = 0;
        stall_cycles = 0;
        idle_on      = 1'b1;
        motif_reg    = '0;
        mlen_reg     = LEN_RESET;
        clear_sequence();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Reset motif is four zero bytes: overlapping sites, the last one on the final item.
        push_chars('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00});
        load_motif({{6{8'hFF}}, 8'hFF, 8'h00}, 4'd2);
        push_chars('{8'h00, 8'hFF, 8'h00, 8'hFF, 8'hFF});
        // A sequence shorter than the motif yields only a summary.
        load_motif({{6{8'hFF}}, 8'hFF, 8'h00}, 4'd8);
        push_chars('{8'h00});
        // Length zero acts as one: a single site first, then two.
        load_motif({{7{8'h5A}}, 8'h00}, 4'd0);
        push_chars('{8'hFF, 8'h00, 8'hFF});
        push_chars('{8'h00, 8'h00});
        // Length above the maximum acts as the maximum.
        load_motif({8{8'hA5}}, 4'd15);
        push_chars('{8'hA5, 8'hA5, 8'hA5, 8'hA5, 8'hA5, 8'hA5, 8'hA5, 8'hA5});

        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0:       len = 4'd1;
                1:       len = 4'd8;
                2:       len = 4'd0;
                3:       len = 4'd15;
                default: len = LEN_W'(($urandom_range(0, 4) == 0) ? $urandom_range(9, 14)
                                                                  : $urandom_range(1, 8));
            endcase
            b0 = CHAR_W'($urandom_range(0, 255));
            b1 = CHAR_W'($urandom_range(0, 255));
            if (ph == 4)
                chars = '1;
            else if (ph == 5)
                chars = '0;
            else
                case ($urandom_range(0, 2))
                    0:       chars = {$urandom, $urandom};
                    1:       chars = {8{b0}};
                    default: chars = {4{b1, b0}};
                endcase
            load_motif(chars, len);
            idle_on = (ph != 3 && ph != NUM_PHASES - 1);
            added = 0;
            while (added < PHASE_ITEMS)
            begin
                if (ph == 6 && added == 0)
                begin
                    // Stop mid-sequence until the scanner has caught up, then go on.
                    add_sequence(10, 1'b0);
                    wait_idle();
                    added += 10;
                end
                n = ($urandom_range(0, 19) == 0) ? $urandom_range(60, 200)
                                                 : $urandom_range(1, 24);
                add_sequence(n, 1'b1);
                added += n;
            end
        end

        wait_idle();
        if (due_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", due_results.size()));
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

>>> sim.f
rtl/msds_pkg.sv
rtl/msds_cell.sv
rtl/msds_tracker.sv
rtl/msds_result_fifo.sv
rtl/motif_site_distance_scanner.sv
rtl/msds_checker.sv
sim/tb_motif_site_distance_scanner.sv
